### rtl/core/scrs_pkg.sv
// ----------------------------------------------------------------------------
// scrs_pkg
// Shared types, constants and helper functions of the slave clock rate
// synchroniser.
// ----------------------------------------------------------------------------
package scrs_pkg;

    localparam int unsigned HALF_DAY_SECONDS = 43200;

    localparam logic [1:0] CFG_MAX_RATE    = 2'd0;
    localparam logic [1:0] CFG_HOUR_OFFSET = 2'd1;
    localparam logic [1:0] CFG_SYNC_WINDOW = 2'd2;
    localparam logic [1:0] CFG_ACTIVE      = 2'd3;

    localparam logic [4:0]  MAX_RATE_RESET    = 5'd10;
    localparam logic [4:0]  HOUR_OFFSET_RESET = 5'd0;
    localparam logic [14:0] SYNC_WINDOW_RESET = 15'd60;

    localparam logic [1:0] PULSE_NONE   = 2'd0;
    localparam logic [1:0] PULSE_FIRST  = 2'd1;
    localparam logic [1:0] PULSE_SECOND = 2'd2;

    typedef enum logic [1:0] {
        MODE_LOCAL_STEP   = 2'd0,
        MODE_NET_STEP     = 2'd1,
        MODE_NET_UPDATE   = 2'd2,
        MODE_STARTUP_LOAD = 2'd3
    } mode_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_APPLY,
        ST_TIME,
        ST_DELTA,
        ST_DECIDE,
        ST_CATCH_START,
        ST_CATCH_WAIT,
        ST_WAIT_START,
        ST_WAIT_WAIT,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [3:0] h;
        logic [5:0] m;
        logic [5:0] s;
    } clk_time_t;

    typedef struct packed {
        logic capture;
        logic apply;
        logic calc_time;
        logic calc_delta;
        logic decide;
        logic div_start;
        logic div_sel;
        logic store_catchup;
        logic finish_div;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic need_decision;
        logic div_needed;
        logic div_done;
        logic out_free;
    } status_t;

    function automatic logic [7:0] top_rate(input logic [4:0] max_rate);
        logic [7:0] r;
        r = {max_rate, 3'b000} + {2'b00, max_rate, 1'b0};
        if (max_rate > 5'd25)
        begin
            r = 8'd250;
        end
        return r;
    endfunction

    function automatic logic [3:0] mod12(input logic [5:0] v);
        logic [5:0] r;
        priority if (v >= 6'd60)
        begin
            r = v - 6'd60;
        end
        else if (v >= 6'd48)
        begin
            r = v - 6'd48;
        end
        else if (v >= 6'd36)
        begin
            r = v - 6'd36;
        end
        else if (v >= 6'd24)
        begin
            r = v - 6'd24;
        end
        else if (v >= 6'd12)
        begin
            r = v - 6'd12;
        end
        else
        begin
            r = v;
        end
        return r[3:0];
    endfunction

    function automatic clk_time_t tick_second(input clk_time_t t);
        clk_time_t r;
        r = t;
        r.s = t.s + 6'd1;
        if (r.s >= 6'd60)
        begin
            r.s = '0;
            r.m = t.m + 6'd1;
        end
        if (r.m >= 6'd60)
        begin
            r.m = '0;
            r.h = r.h + 4'd1;
        end
        if (r.h >= 4'd12)
        begin
            r.h = '0;
        end
        return r;
    endfunction

endpackage

### rtl/core/scrs_div.sv
// ----------------------------------------------------------------------------
// scrs_div
// Restoring divider, 16-bit dividend by 8-bit divisor, one quotient bit per
// cycle.
// ----------------------------------------------------------------------------
module scrs_div
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [15:0] dividend,
    input  logic [7:0]  divisor,
    output logic        done,
    output logic [15:0] quotient
);

    logic        busy_reg, busy_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        done_reg, done_next;
    logic [7:0]  rem_reg, rem_next;
    logic [15:0] quo_reg, quo_next;
    logic [7:0]  dsr_reg, dsr_next;
    logic [8:0]  shifted;
    logic [8:0]  trial;

    always_comb
    begin
        shifted   = {rem_reg, quo_reg[15]};
        trial     = shifted - {1'b0, dsr_reg};
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = 5'd16;
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (shifted >= {1'b0, dsr_reg})
            begin
                rem_next = trial[7:0];
                quo_next = {quo_reg[14:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[7:0];
                quo_next = {quo_reg[14:0], 1'b0};
            end
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

### rtl/core/scrs_dp.sv
// ----------------------------------------------------------------------------
// scrs_dp
// Datapath: configuration registers, local and network clocks, difference
// and rate decision, divider and output register.
// ----------------------------------------------------------------------------
module scrs_dp
    import scrs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    output status_t     status,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [14:0] cfg_data,
    input  logic [1:0]  mode,
    input  logic [4:0]  hours,
    input  logic [5:0]  minutes,
    input  logic [5:0]  seconds,
    input  logic [7:0]  rate_tenths,
    input  logic        stopped,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  local_hours,
    output logic [5:0]  local_minutes,
    output logic [5:0]  local_seconds,
    output logic [7:0]  local_rate,
    output logic        rate_changed,
    output logic [1:0]  pulse_coil,
    output logic        update_accepted
);

    localparam logic signed [17:0] HALF_DAY_S  = 18'(HALF_DAY_SECONDS);
    localparam logic signed [17:0] FULL_DAY_S  = 18'(2 * HALF_DAY_SECONDS);
    localparam logic [16:0]        HALF_DAY_17 = 17'(HALF_DAY_SECONDS);
    localparam logic [15:0]        HALF_DAY_16 = 16'(HALF_DAY_SECONDS);

    // configuration
    logic [4:0]  max_rate_reg;
    logic [4:0]  hour_offset_reg;
    logic [14:0] sync_window_reg;
    logic        active_reg;

    // clock state
    clk_time_t   our_time_reg, our_time_next;
    logic [7:0]  our_rate_reg, our_rate_next;
    clk_time_t   net_time_reg, net_time_next;
    logic [7:0]  net_rate_reg, net_rate_next;
    logic        toggle_reg, toggle_next;

    // captured request
    mode_t       mode_reg;
    logic [4:0]  hours_reg;
    logic [5:0]  minutes_reg;
    logic [5:0]  seconds_reg;
    logic [7:0]  rate_reg;
    logic        stopped_reg;
    logic [7:0]  old_rate_reg;
    logic [1:0]  pulse_reg, pulse_next;
    logic        accepted_reg, accepted_next;

    // decision working registers
    logic [15:0] nt_reg;
    logic [15:0] ot_reg;
    logic [15:0] d_reg;
    logic [15:0] catchup_reg;

    // output register
    logic        out_valid_reg;
    logic [3:0]  lh_reg;
    logic [5:0]  lm_reg;
    logic [5:0]  ls_reg;
    logic [7:0]  lr_reg;
    logic        rc_reg;
    logic [1:0]  pc_reg;
    logic        ua_reg;

    logic [7:0]        mx;
    logic              range_ok;
    logic signed [6:0] hsum;
    clk_time_t         load_time;
    clk_time_t         upd_time;
    logic [15:0]       nt_calc;
    logic [15:0]       ot_calc;
    logic signed [17:0] diff;
    logic signed [17:0] p1;
    logic signed [17:0] p2;
    logic signed [17:0] m1;
    logic signed [17:0] d_sel;
    logic [16:0]       d17;
    logic [16:0]       w17;
    logic [16:0]       hw17;
    logic              near_w;
    logic              near_h;
    logic              rule_hold;
    logic              rule_match;
    logic              rule_run;
    logic              rule_stop;
    logic [15:0]       div_dividend;
    logic [7:0]        div_divisor;
    logic              div_done;
    logic [15:0]       div_quo;

    assign mx       = top_rate(max_rate_reg);
    assign range_ok = (hours_reg < 5'd24) && (minutes_reg < 6'd60) && (seconds_reg < 6'd60);
    assign hsum     = $signed({2'b00, hours_reg})
                    + $signed({{2{hour_offset_reg[4]}}, hour_offset_reg}) + 7'sd24;

    always_comb
    begin
        load_time.h = mod12({1'b0, hours_reg});
        load_time.m = minutes_reg;
        load_time.s = seconds_reg;
        upd_time.h  = mod12(hsum[5:0]);
        upd_time.m  = minutes_reg;
        upd_time.s  = seconds_reg;
    end

    // seconds since twelve o'clock
    assign nt_calc = {12'b0, net_time_reg.h} * 16'd3600 + {10'b0, net_time_reg.m} * 16'd60
                   + {10'b0, net_time_reg.s};
    assign ot_calc = {12'b0, our_time_reg.h} * 16'd3600 + {10'b0, our_time_reg.m} * 16'd60
                   + {10'b0, our_time_reg.s};

    // difference reduced into one half day
    always_comb
    begin
        diff = $signed({2'b00, nt_reg}) - $signed({2'b00, ot_reg});
        p1   = diff + HALF_DAY_S;
        p2   = diff + FULL_DAY_S;
        m1   = diff - HALF_DAY_S;
        priority if (diff < 18'sd0)
        begin
            d_sel = (p1 < 18'sd0) ? p2 : p1;
        end
        else if (diff >= HALF_DAY_S)
        begin
            d_sel = m1;
        end
        else
        begin
            d_sel = diff;
        end
    end

    assign d17        = {1'b0, d_reg};
    assign w17        = {2'b00, sync_window_reg};
    assign hw17       = {3'b000, sync_window_reg[14:1]};
    assign near_w     = (d17 < w17) || (d17 > HALF_DAY_17 - w17);
    assign near_h     = (d17 < hw17) || (d17 > HALF_DAY_17 - hw17);
    assign rule_hold  = near_w && (net_rate_reg == our_rate_reg);
    assign rule_match = near_h && (net_rate_reg <= mx);
    assign rule_run   = (net_rate_reg == 8'd0);
    assign rule_stop  = (net_rate_reg >= mx);

    assign div_dividend = cmd.div_sel ? (HALF_DAY_16 - d_reg) : d_reg;
    assign div_divisor  = cmd.div_sel ? net_rate_reg : (mx - net_rate_reg);

    scrs_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_comb
    begin
        status.need_decision = (mode_reg != MODE_STARTUP_LOAD) && active_reg
                             && ((mode_reg != MODE_NET_UPDATE) || range_ok);
        status.div_needed    = !(rule_hold || rule_match || rule_run || rule_stop);
        status.div_done      = div_done;
        status.out_free      = !out_valid_reg || out_ready;
    end

    always_comb
    begin
        our_time_next = our_time_reg;
        our_rate_next = our_rate_reg;
        net_time_next = net_time_reg;
        net_rate_next = net_rate_reg;
        toggle_next   = toggle_reg;
        pulse_next    = pulse_reg;
        accepted_next = accepted_reg;
        if (cmd.capture)
        begin
            pulse_next    = PULSE_NONE;
            accepted_next = 1'b0;
        end
        if (cmd.apply)
        begin
            unique case (mode_reg)
                MODE_STARTUP_LOAD:
                begin
                    our_time_next = load_time;
                    our_rate_next = (rate_reg > mx) ? mx : rate_reg;
                    net_time_next = load_time;
                    net_rate_next = rate_reg;
                end
                MODE_LOCAL_STEP:
                begin
                    if (active_reg)
                    begin
                        pulse_next    = toggle_reg ? PULSE_FIRST : PULSE_SECOND;
                        toggle_next   = !toggle_reg;
                        our_time_next = tick_second(our_time_reg);
                    end
                end
                MODE_NET_STEP:
                begin
                    if (active_reg)
                    begin
                        net_time_next = tick_second(net_time_reg);
                    end
                end
                MODE_NET_UPDATE:
                begin
                    if (active_reg && range_ok)
                    begin
                        net_time_next = upd_time;
                        net_rate_next = stopped_reg ? 8'd0 : rate_reg;
                        accepted_next = 1'b1;
                    end
                end
            endcase
        end
        if (cmd.decide)
        begin
            priority if (rule_hold)
            begin
                our_rate_next = our_rate_reg;
            end
            else if (rule_match)
            begin
                our_rate_next = net_rate_reg;
            end
            else if (rule_run)
            begin
                our_rate_next = mx;
            end
            else if (rule_stop)
            begin
                our_rate_next = 8'd0;
            end
            else
            begin
                our_rate_next = our_rate_reg;
            end
        end
        if (cmd.finish_div)
        begin
            our_rate_next = (div_quo <= catchup_reg) ? 8'd0 : mx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_rate_reg    <= MAX_RATE_RESET;
            hour_offset_reg <= HOUR_OFFSET_RESET;
            sync_window_reg <= SYNC_WINDOW_RESET;
            active_reg      <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MAX_RATE:    max_rate_reg    <= cfg_data[4:0];
                CFG_HOUR_OFFSET: hour_offset_reg <= cfg_data[4:0];
                CFG_SYNC_WINDOW: sync_window_reg <= cfg_data;
                CFG_ACTIVE:      active_reg      <= cfg_data[0];
                default:         active_reg      <= active_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            our_time_reg  <= '0;
            our_rate_reg  <= '0;
            net_time_reg  <= '0;
            net_rate_reg  <= '0;
            toggle_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            our_time_reg <= our_time_next;
            our_rate_reg <= our_rate_next;
            net_time_reg <= net_time_next;
            net_rate_reg <= net_rate_next;
            toggle_reg   <= toggle_next;
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pulse_reg    <= pulse_next;
        accepted_reg <= accepted_next;
        if (cmd.capture)
        begin
            mode_reg     <= mode_t'(mode);
            hours_reg    <= hours;
            minutes_reg  <= minutes;
            seconds_reg  <= seconds;
            rate_reg     <= rate_tenths;
            stopped_reg  <= stopped;
            old_rate_reg <= our_rate_reg;
        end
        if (cmd.calc_time)
        begin
            nt_reg <= nt_calc;
            ot_reg <= ot_calc;
        end
        if (cmd.calc_delta)
        begin
            d_reg <= d_sel[15:0];
        end
        if (cmd.store_catchup)
        begin
            catchup_reg <= div_quo;
        end
        if (cmd.emit)
        begin
            lh_reg <= our_time_reg.h;
            lm_reg <= our_time_reg.m;
            ls_reg <= our_time_reg.s;
            lr_reg <= our_rate_reg;
            rc_reg <= (our_rate_reg != old_rate_reg);
            pc_reg <= pulse_reg;
            ua_reg <= accepted_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign local_hours     = lh_reg;
    assign local_minutes   = lm_reg;
    assign local_seconds   = ls_reg;
    assign local_rate      = lr_reg;
    assign rate_changed    = rc_reg;
    assign pulse_coil      = pc_reg;
    assign update_accepted = ua_reg;

endmodule

### rtl/core/scrs_ctrl.sv
// ----------------------------------------------------------------------------
// scrs_ctrl
// Controller: sequences capture, state update, rate decision, the two
// divisions and the hand-over to the output register.
// ----------------------------------------------------------------------------
module scrs_ctrl
    import scrs_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY:       state_next = status.need_decision ? ST_TIME : ST_EMIT;
            ST_TIME:        state_next = ST_DELTA;
            ST_DELTA:       state_next = ST_DECIDE;
            ST_DECIDE:      state_next = status.div_needed ? ST_CATCH_START : ST_EMIT;
            ST_CATCH_START: state_next = ST_CATCH_WAIT;
            ST_CATCH_WAIT:
            begin
                if (status.div_done)
                begin
                    state_next = ST_WAIT_START;
                end
            end
            ST_WAIT_START:  state_next = ST_WAIT_WAIT;
            ST_WAIT_WAIT:
            begin
                if (status.div_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:        state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            ST_IDLE:        cmd.capture = in_valid;
            ST_APPLY:       cmd.apply = 1'b1;
            ST_TIME:        cmd.calc_time = 1'b1;
            ST_DELTA:       cmd.calc_delta = 1'b1;
            ST_DECIDE:      cmd.decide = 1'b1;
            ST_CATCH_START: cmd.div_start = 1'b1;
            ST_CATCH_WAIT:  cmd.store_catchup = status.div_done;
            ST_WAIT_START:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = 1'b1;
            end
            ST_WAIT_WAIT:   cmd.finish_div = status.div_done;
            ST_EMIT:        cmd.emit = status.out_free;
            default:        cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

endmodule

### rtl/core/slave_clock_rate_sync_unit.sv
// ----------------------------------------------------------------------------
// slave_clock_rate_sync_unit
// Keeps a local and a network 12-hour clock and, while active, picks the local
// rate after every step or accepted network update.
//
// One request is worked on at a time. A request that needs no rate decision
// (startup load, inactive clock, rejected update) goes from the apply state
// straight to the emit state; one decided by the hold, match, run or stop
// rules also passes the time, delta and decide states; one that must compare
// catching up against waiting also runs the shared one-bit-per-cycle divider,
// which forms the two quotients one after the other, each from a start state
// through a wait state. The result sits in an output register, so the next
// request is taken while it waits; a request finishes only once that register is free.
// ----------------------------------------------------------------------------
module slave_clock_rate_sync_unit
    import scrs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [14:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  mode,
    input  logic [4:0]  hours,
    input  logic [5:0]  minutes,
    input  logic [5:0]  seconds,
    input  logic [7:0]  rate_tenths,
    input  logic        stopped,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  local_hours,
    output logic [5:0]  local_minutes,
    output logic [5:0]  local_seconds,
    output logic [7:0]  local_rate,
    output logic        rate_changed,
    output logic [1:0]  pulse_coil,
    output logic        update_accepted
);

    cmd_t    cmd;
    status_t status;

    scrs_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    scrs_dp u_dp
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .mode            (mode),
        .hours           (hours),
        .minutes         (minutes),
        .seconds         (seconds),
        .rate_tenths     (rate_tenths),
        .stopped         (stopped),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .local_hours     (local_hours),
        .local_minutes   (local_minutes),
        .local_seconds   (local_seconds),
        .local_rate      (local_rate),
        .rate_changed    (rate_changed),
        .pulse_coil      (pulse_coil),
        .update_accepted (update_accepted)
    );

endmodule
